FILE: sv/rpfa_pkg.sv
`timescale 1ns / 1ps
package rpfa_pkg;

	localparam int ADDR_W     = 32;
	localparam int NUM_PAGES  = 32768;
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int IDX_W      = $clog2(NUM_PAGES);
	localparam int FP_W       = $clog2(NUM_PAGES + 1);
	localparam int CNT_W      = 8;
	localparam int OP_W       = 3;
	localparam int ST_W       = 3;
	localparam int CFG_IDX_W  = 2;

	// Page numbers (rounded-up addresses shifted down) plus room for sums and borrows.
	localparam int PN_W = ADDR_W - PAGE_SHIFT + 1;
	localparam int UW   = ((PN_W > IDX_W + 1) ? PN_W : IDX_W + 1) + 1;

	localparam logic [UW-1:0]    NUM_PAGES_U = UW'(NUM_PAGES);
	localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(NUM_PAGES - 1);
	localparam logic [CNT_W-1:0] CNT_MAX     = '1;

	localparam logic [OP_W-1:0] OP_INIT     = 3'd0;
	localparam logic [OP_W-1:0] OP_ALLOC    = 3'd1;
	localparam logic [OP_W-1:0] OP_FREE     = 3'd2;
	localparam logic [OP_W-1:0] OP_ADD_REF  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_REF = 3'd4;

	localparam logic [ST_W-1:0] STAT_OK        = 3'd0;
	localparam logic [ST_W-1:0] STAT_OOM       = 3'd1;
	localparam logic [ST_W-1:0] STAT_BAD_ADDR  = 3'd2;
	localparam logic [ST_W-1:0] STAT_ZERO      = 3'd3;
	localparam logic [ST_W-1:0] STAT_SATURATED = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_TOP  = 2'd2;

	typedef struct packed {
		logic [UW-1:0] x;
		logic [UW-1:0] y;
		logic          sub;
		logic          cin;
	} alu_req_t;

	typedef struct packed {
		logic [UW-1:0] sum;
		logic          carry;
	} alu_res_t;

	typedef struct packed {
		logic [ADDR_W-1:0] page_address;
		logic [CNT_W-1:0]  ref_count;
		logic [ST_W-1:0]   status;
	} result_t;

	// Page number of an address rounded up to the next page boundary.
	function automatic alu_req_t ceil_req(input logic [ADDR_W-1:0] a);
		alu_req_t r;
		r.x   = UW'(a[ADDR_W-1:PAGE_SHIFT]);
		r.y   = '0;
		r.sub = 1'b0;
		r.cin = |a[PAGE_SHIFT-1:0];
		return r;
	endfunction

	// Carry out of a subtraction is set when x >= y.
	function automatic alu_req_t sub_req(input logic [UW-1:0] x, input logic [UW-1:0] y);
		alu_req_t r;
		r.x   = x;
		r.y   = y;
		r.sub = 1'b1;
		r.cin = 1'b1;
		return r;
	endfunction

	function automatic alu_req_t add_req(input logic [UW-1:0] x, input logic [UW-1:0] y);
		alu_req_t r;
		r.x   = x;
		r.y   = y;
		r.sub = 1'b0;
		r.cin = 1'b0;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] page_addr(input logic [UW-1:0] pn);
		logic [ADDR_W-1:0] a;
		a = {pn[ADDR_W-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}};
		return a;
	endfunction

endpackage

FILE: sv/refcounted_page_frame_allocator_top.sv
`timescale 1ns / 1ps
// Commands share one adder: alloc takes a page from the free list or a fresh page, free rejects
// a misaligned address at once, add_ref and read_ref check it, init sweeps the count table.
// Throughput is one command per busy period; the done strobe follows the last busy cycle and a
// new start is taken in that same cycle. Unused operation codes give done in the cycle after start.
// After reset the count table is cleared, one entry a cycle, with busy high.
// Each result holds on the output ports until the next one; the receiver cannot stall it.
module refcounted_page_frame_allocator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [rpfa_pkg::OP_W-1:0]           operation,
	input  logic [rpfa_pkg::ADDR_W-1:0]         address,
	output logic                                done,
	output logic [rpfa_pkg::ADDR_W-1:0]         page_address,
	output logic [rpfa_pkg::CNT_W-1:0]          ref_count,
	output logic [rpfa_pkg::ST_W-1:0]           status,
	input  logic                                cfg_write,
	input  logic [rpfa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rpfa_pkg::ADDR_W-1:0]         cfg_data
);

	localparam int UW    = rpfa_pkg::UW;
	localparam int IDX_W = rpfa_pkg::IDX_W;
	localparam int CNT_W = rpfa_pkg::CNT_W;
	localparam int FP_W  = rpfa_pkg::FP_W;
	localparam int PS    = rpfa_pkg::PAGE_SHIFT;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_BASE    = 5'd1;
	localparam logic [4:0] S_I_FFA   = 5'd2;
	localparam logic [4:0] S_I_CMP   = 5'd3;
	localparam logic [4:0] S_I_TOP   = 5'd4;
	localparam logic [4:0] S_I_FIRST = 5'd5;
	localparam logic [4:0] S_I_REM   = 5'd6;
	localparam logic [4:0] S_I_CLAMP = 5'd7;
	localparam logic [4:0] S_I_END   = 5'd8;
	localparam logic [4:0] S_SWEEP   = 5'd9;
	localparam logic [4:0] S_A_CHK   = 5'd10;
	localparam logic [4:0] S_A_LINK  = 5'd11;
	localparam logic [4:0] S_A_FRESH = 5'd12;
	localparam logic [4:0] S_A_FPAGE = 5'd13;
	localparam logic [4:0] S_A_FIDX  = 5'd14;
	localparam logic [4:0] S_A_FRNG  = 5'd15;
	localparam logic [4:0] S_ADDR    = 5'd16;
	localparam logic [4:0] S_F_FFA   = 5'd17;
	localparam logic [4:0] S_F_LO    = 5'd18;
	localparam logic [4:0] S_F_TOP   = 5'd19;
	localparam logic [4:0] S_F_HI    = 5'd20;
	localparam logic [4:0] S_IDX     = 5'd21;
	localparam logic [4:0] S_RNG     = 5'd22;
	localparam logic [4:0] S_RD      = 5'd23;

	logic [4:0]                        state_q;
	logic [rpfa_pkg::ADDR_W-1:0]       memory_base_q;
	logic [rpfa_pkg::ADDR_W-1:0]       first_free_q;
	logic [rpfa_pkg::ADDR_W-1:0]       memory_top_q;
	logic [rpfa_pkg::OP_W-1:0]         op_q;
	logic [rpfa_pkg::ADDR_W-1:0]       addr_q;
	logic [UW-1:0]                     base_pn_q;
	logic [UW-1:0]                     start_pn_q;
	logic [UW-1:0]                     first_q;
	logic [UW-1:0]                     n_q;
	logic [UW-1:0]                     end_q;
	logic [UW-1:0]                     r_q;
	logic [UW-1:0]                     tmp_q;
	logic                              ok_q;
	logic [UW-1:0]                     fresh_pn_q;
	logic [FP_W-1:0]                   fp_q;
	logic [IDX_W-1:0]                  head_q;
	logic                              empty_q;
	logic [IDX_W-1:0]                  sweep_q;
	logic                              sweep_clear_q;
	logic                              zone_q;
	logic                              done_q;
	rpfa_pkg::result_t                 res_q;

	rpfa_pkg::alu_req_t                alu_req;
	rpfa_pkg::alu_res_t                alu_res;
	logic                              zone_now;
	logic [UW-1:0]                     sweep_u;
	logic [UW-1:0]                     floor_top;
	logic [IDX_W-1:0]                  idx;
	logic [CNT_W-1:0]                  new_cnt;

	logic                              cnt_we;
	logic [IDX_W-1:0]                  cnt_waddr;
	logic [CNT_W-1:0]                  cnt_wdata;
	logic [CNT_W-1:0]                  cnt_rdata;
	logic                              lnk_we;
	logic [IDX_W-1:0]                  lnk_wdata;
	logic [IDX_W-1:0]                  lnk_rdata;

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign page_address = res_q.page_address;
	assign ref_count    = res_q.ref_count;
	assign status       = res_q.status;

	assign idx       = tmp_q[IDX_W-1:0];
	assign new_cnt   = alu_res.sum[CNT_W-1:0];
	assign sweep_u   = UW'(sweep_q);
	assign floor_top = UW'(memory_top_q[rpfa_pkg::ADDR_W-1:PS]);

	// The fresh range opens at its first index and closes at its end index as the sweep walks up.
	assign zone_now = (sweep_u == first_q) ? (first_q != end_q) :
		((sweep_u == end_q) ? 1'b0 : zone_q);

	rpfa_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	rpfa_ram #(
		.DEPTH (rpfa_pkg::NUM_PAGES),
		.WIDTH (CNT_W)
	) u_counts (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (idx),
		.rdata (cnt_rdata)
	);

	rpfa_ram #(
		.DEPTH (rpfa_pkg::NUM_PAGES),
		.WIDTH (IDX_W)
	) u_links (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (idx),
		.wdata (lnk_wdata),
		.raddr (head_q),
		.rdata (lnk_rdata)
	);

	always_comb begin
		alu_req = '0;
		case (state_q)
			S_BASE:    alu_req = rpfa_pkg::ceil_req(memory_base_q);
			S_I_FFA:   alu_req = rpfa_pkg::ceil_req(first_free_q);
			S_I_CMP:   alu_req = rpfa_pkg::sub_req(start_pn_q, base_pn_q);
			S_I_TOP:   alu_req = rpfa_pkg::sub_req(floor_top, start_pn_q);
			S_I_FIRST: alu_req = rpfa_pkg::sub_req(first_q, rpfa_pkg::NUM_PAGES_U);
			S_I_REM:   alu_req = rpfa_pkg::sub_req(rpfa_pkg::NUM_PAGES_U, first_q);
			S_I_CLAMP: alu_req = rpfa_pkg::sub_req(n_q, tmp_q);
			S_I_END:   alu_req = rpfa_pkg::add_req(first_q, n_q);
			S_A_LINK:  alu_req = rpfa_pkg::add_req(base_pn_q, UW'(head_q));
			S_A_FRESH: alu_req = rpfa_pkg::sub_req(UW'(fp_q), UW'(1));
			S_A_FPAGE: alu_req = rpfa_pkg::add_req(fresh_pn_q, UW'(fp_q));
			S_A_FIDX:  alu_req = rpfa_pkg::sub_req(r_q, base_pn_q);
			S_A_FRNG:  alu_req = rpfa_pkg::sub_req(tmp_q, rpfa_pkg::NUM_PAGES_U);
			S_ADDR:    alu_req = rpfa_pkg::ceil_req(addr_q);
			S_F_FFA:   alu_req = rpfa_pkg::ceil_req(first_free_q);
			S_F_LO:    alu_req = rpfa_pkg::sub_req(r_q, tmp_q);
			S_F_TOP:   alu_req = rpfa_pkg::ceil_req(memory_top_q);
			S_F_HI:    alu_req = rpfa_pkg::sub_req(r_q, tmp_q);
			S_IDX:     alu_req = rpfa_pkg::sub_req(r_q, base_pn_q);
			S_RNG:     alu_req = rpfa_pkg::sub_req(tmp_q, rpfa_pkg::NUM_PAGES_U);
			S_RD: begin
				if (op_q == rpfa_pkg::OP_FREE) begin
					alu_req = rpfa_pkg::sub_req(UW'(cnt_rdata), UW'(1));
				end else begin
					alu_req = rpfa_pkg::add_req(UW'(cnt_rdata), UW'(1));
				end
			end
			default: alu_req = '0;
		endcase
	end

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = idx;
		cnt_wdata = CNT_W'(1);
		lnk_we    = 1'b0;
		lnk_wdata = empty_q ? idx : head_q;
		case (state_q)
			S_SWEEP: begin
				cnt_we    = 1'b1;
				cnt_waddr = sweep_q;
				cnt_wdata = (sweep_clear_q || zone_now) ? '0 : CNT_W'(1);
			end
			S_A_LINK: begin
				cnt_we    = 1'b1;
				cnt_waddr = head_q;
			end
			S_A_FRNG: begin
				cnt_we = !alu_res.carry;
			end
			S_RD: begin
				case (op_q)
					rpfa_pkg::OP_FREE: begin
						if (cnt_rdata != '0) begin
							cnt_we    = 1'b1;
							cnt_wdata = new_cnt;
							lnk_we    = (new_cnt == '0);
						end
					end
					rpfa_pkg::OP_ADD_REF: begin
						if (cnt_rdata != rpfa_pkg::CNT_MAX) begin
							cnt_we    = 1'b1;
							cnt_wdata = new_cnt;
						end
					end
					default: cnt_we = 1'b0;
				endcase
			end
			default: cnt_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			memory_base_q <= 32'h8000_0000;
			first_free_q  <= 32'h8000_0000;
			memory_top_q  <= 32'h8800_0000;
			op_q          <= '0;
			addr_q        <= '0;
			base_pn_q     <= '0;
			start_pn_q    <= '0;
			first_q       <= '0;
			n_q           <= '0;
			end_q         <= '0;
			r_q           <= '0;
			tmp_q         <= '0;
			ok_q          <= 1'b0;
			fresh_pn_q    <= '0;
			fp_q          <= '0;
			head_q        <= '0;
			empty_q       <= 1'b1;
			sweep_q       <= '0;
			sweep_clear_q <= 1'b1;
			zone_q        <= 1'b0;
			done_q        <= 1'b0;
			res_q         <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_write) begin
				case (cfg_index)
					rpfa_pkg::CFG_MEMORY_BASE: memory_base_q <= cfg_data;
					rpfa_pkg::CFG_FIRST_FREE:  first_free_q  <= cfg_data;
					rpfa_pkg::CFG_MEMORY_TOP:  memory_top_q  <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q   <= operation;
						addr_q <= address;
						if (operation > rpfa_pkg::OP_READ_REF) begin
							done_q <= 1'b1;
							res_q  <= '0;
						end else begin
							state_q <= S_BASE;
						end
					end
				end
				S_BASE: begin
					base_pn_q <= alu_res.sum;
					case (op_q)
						rpfa_pkg::OP_INIT:  state_q <= S_I_FFA;
						rpfa_pkg::OP_ALLOC: state_q <= S_A_CHK;
						rpfa_pkg::OP_FREE: begin
							if (addr_q[PS-1:0] != '0) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
								res_q   <= '{page_address: '0, ref_count: '0,
									status: rpfa_pkg::STAT_BAD_ADDR};
							end else begin
								state_q <= S_ADDR;
							end
						end
						default: state_q <= S_ADDR;
					endcase
				end
				S_I_FFA: begin
					start_pn_q <= alu_res.sum;
					state_q    <= S_I_CMP;
				end
				S_I_CMP: begin
					// A kernel image ending below the base leaves the whole table usable.
					if (alu_res.carry) begin
						first_q <= alu_res.sum;
					end else begin
						first_q    <= '0;
						start_pn_q <= base_pn_q;
					end
					state_q <= S_I_TOP;
				end
				S_I_TOP: begin
					n_q     <= alu_res.sum;
					ok_q    <= alu_res.carry && (alu_res.sum != '0);
					state_q <= S_I_FIRST;
				end
				S_I_FIRST: begin
					if (alu_res.carry) begin
						ok_q <= 1'b0;
					end
					state_q <= S_I_REM;
				end
				S_I_REM: begin
					tmp_q   <= alu_res.sum;
					state_q <= S_I_CLAMP;
				end
				S_I_CLAMP: begin
					if (!ok_q) begin
						n_q <= '0;
					end else if (alu_res.carry) begin
						n_q <= tmp_q;
					end
					state_q <= S_I_END;
				end
				S_I_END: begin
					end_q      <= alu_res.sum;
					fp_q       <= n_q[FP_W-1:0];
					fresh_pn_q <= start_pn_q;
					head_q     <= '0;
					empty_q    <= 1'b1;
					sweep_q    <= '0;
					zone_q     <= 1'b0;
					state_q    <= S_SWEEP;
				end
				S_SWEEP: begin
					zone_q  <= zone_now;
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == rpfa_pkg::LAST_IDX) begin
						state_q       <= S_IDLE;
						sweep_clear_q <= 1'b0;
						if (!sweep_clear_q) begin
							done_q <= 1'b1;
							res_q  <= '0;
						end
					end
				end
				S_A_CHK: begin
					if (!empty_q) begin
						state_q <= S_A_LINK;
					end else if (fp_q != '0) begin
						state_q <= S_A_FRESH;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= '{page_address: '0, ref_count: '0,
							status: rpfa_pkg::STAT_OOM};
					end
				end
				S_A_LINK: begin
					// A page linked to itself marks the tail of the free list.
					if (lnk_rdata == head_q) begin
						empty_q <= 1'b1;
						head_q  <= '0;
					end else begin
						head_q <= lnk_rdata;
					end
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					res_q   <= '{page_address: rpfa_pkg::page_addr(alu_res.sum),
						ref_count: CNT_W'(1), status: rpfa_pkg::STAT_OK};
				end
				S_A_FRESH: begin
					fp_q    <= alu_res.sum[FP_W-1:0];
					state_q <= S_A_FPAGE;
				end
				S_A_FPAGE: begin
					r_q     <= alu_res.sum;
					state_q <= S_A_FIDX;
				end
				S_A_FIDX: begin
					tmp_q <= alu_res.sum;
					if (alu_res.carry) begin
						state_q <= S_A_FRNG;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= '{page_address: rpfa_pkg::page_addr(r_q),
							ref_count: CNT_W'(1), status: rpfa_pkg::STAT_OK};
					end
				end
				S_A_FRNG: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					res_q   <= '{page_address: rpfa_pkg::page_addr(r_q),
						ref_count: CNT_W'(1), status: rpfa_pkg::STAT_OK};
				end
				S_ADDR: begin
					r_q     <= alu_res.sum;
					state_q <= (op_q == rpfa_pkg::OP_FREE) ? S_F_FFA : S_IDX;
				end
				S_F_FFA: begin
					tmp_q   <= alu_res.sum;
					state_q <= S_F_LO;
				end
				S_F_LO: begin
					// The address is page aligned here, so page numbers compare like bytes.
					if (!alu_res.carry) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= '{page_address: '0, ref_count: '0,
							status: rpfa_pkg::STAT_BAD_ADDR};
					end else begin
						state_q <= S_F_TOP;
					end
				end
				S_F_TOP: begin
					tmp_q   <= alu_res.sum;
					state_q <= S_F_HI;
				end
				S_F_HI: begin
					if (alu_res.carry) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= '{page_address: '0, ref_count: '0,
							status: rpfa_pkg::STAT_BAD_ADDR};
					end else begin
						state_q <= S_IDX;
					end
				end
				S_IDX: begin
					tmp_q <= alu_res.sum;
					if (!alu_res.carry) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= '{page_address: '0, ref_count: '0,
							status: rpfa_pkg::STAT_BAD_ADDR};
					end else begin
						state_q <= S_RNG;
					end
				end
				S_RNG: begin
					if (alu_res.carry) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						res_q   <= '{page_address: '0, ref_count: '0,
							status: rpfa_pkg::STAT_BAD_ADDR};
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					case (op_q)
						rpfa_pkg::OP_FREE: begin
							if (cnt_rdata == '0) begin
								res_q <= '{page_address: '0, ref_count: '0,
									status: rpfa_pkg::STAT_ZERO};
							end else begin
								res_q <= '{page_address: '0, ref_count: new_cnt,
									status: rpfa_pkg::STAT_OK};
								if (new_cnt == '0) begin
									head_q  <= idx;
									empty_q <= 1'b0;
								end
							end
						end
						rpfa_pkg::OP_ADD_REF: begin
							if (cnt_rdata == rpfa_pkg::CNT_MAX) begin
								res_q <= '{page_address: '0, ref_count: rpfa_pkg::CNT_MAX,
									status: rpfa_pkg::STAT_SATURATED};
							end else begin
								res_q <= '{page_address: '0, ref_count: new_cnt,
									status: rpfa_pkg::STAT_OK};
							end
						end
						default: begin
							res_q <= '{page_address: '0, ref_count: cnt_rdata,
								status: rpfa_pkg::STAT_OK};
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) empty_q |-> (head_q == '0))
		else $error("free list head is nonzero while the list is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		fp_q <= FP_W'(rpfa_pkg::NUM_PAGES))
		else $error("fresh page pointer exceeds the page count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == rpfa_pkg::STAT_OOM)) |-> ((page_address == '0) && (ref_count == '0)))
		else $error("out of memory result carries a page or a count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither started nor completed");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result strobe without a command in progress");

endmodule

FILE: sv/rpfa_alu.sv
`timescale 1ns / 1ps
module rpfa_alu (
	input  rpfa_pkg::alu_req_t req,
	output rpfa_pkg::alu_res_t res
);

	logic [rpfa_pkg::UW:0] total;

	assign total = {1'b0, req.x} + {1'b0, (req.sub ? ~req.y : req.y)}
		+ {{rpfa_pkg::UW{1'b0}}, req.cin};
	assign res.sum   = total[rpfa_pkg::UW-1:0];
	assign res.carry = total[rpfa_pkg::UW];

endmodule

FILE: sv/rpfa_ram.sv
`timescale 1ns / 1ps
module rpfa_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
